[rtl/mcs_pkg.sv]
// Shared types, constants and display tables for the multiplexed clock unit.
package mcs_pkg;

    localparam int DIGIT_COUNT      = 6;
    localparam int SCAN_W           = 3;
    localparam int HOLD_W           = 8;
    localparam int SEC_W            = 6;
    localparam int MIN_W            = 6;
    localparam int HOUR_W           = 5;
    localparam int SEG_W            = 8;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [HOLD_W-1:0] HOLD_LIMIT_RESET = 8'd15;
    localparam logic [SEC_W-1:0]  SEC_WRAP         = 6'd60;
    localparam logic [MIN_W-1:0]  MIN_WRAP         = 6'd60;
    localparam logic [HOUR_W-1:0] HOUR_WRAP        = 5'd24;
    localparam logic [SEG_W-1:0]  SEG_RESET        = 8'h00;
    localparam logic [SEG_W-1:0]  EN_ALL_OFF       = 8'hFF;

    // register index taken from the word address
    localparam logic REG_HOLD_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        CMD_SECOND = 3'd0,
        CMD_SCAN   = 3'd1,
        CMD_HOLD   = 3'd2,
        CMD_SET    = 3'd3,
        CMD_HOUR   = 3'd4,
        CMD_MINUTE = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [MIN_W-1:0]  min;
        logic [HOUR_W-1:0] hour;
        logic [SCAN_W-1:0] scan;
        logic [HOLD_W-1:0] hold;
        logic              adjust;
        logic [SEG_W-1:0]  seg;
        logic [SEG_W-1:0]  en;
    } t_state;

    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd50)      t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] r;
        r = v - {2'b00, tens_of(v)} * 6'd10;
        return r[3:0];
    endfunction

    function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0: s = 8'hBF;
            4'd1: s = 8'h86;
            4'd2: s = 8'hDB;
            4'd3: s = 8'hCF;
            4'd4: s = 8'hE6;
            4'd5: s = 8'hED;
            4'd6: s = 8'hFD;
            4'd7: s = 8'h87;
            4'd8: s = 8'hFF;
            4'd9: s = 8'hEF;
            default: s = 8'hBF;
        endcase
        return s;
    endfunction

    function automatic logic [SEG_W-1:0] digit_enable(input logic [SCAN_W-1:0] idx);
        logic [SEG_W-1:0] e;
        case (idx)
            3'd1: e = 8'hEF;
            3'd2: e = 8'hF7;
            3'd3: e = 8'hFB;
            3'd4: e = 8'hFD;
            3'd5: e = 8'hFE;
            default: e = 8'hDF;
        endcase
        return e;
    endfunction

endpackage

[rtl/multiplexed_clock_with_set_mode_unit.sv]
// Top level of the multiplexed 24-hour clock with set mode and its register port.
// One request per event; a new request can be taken every cycle while o_in_stall is
// low. A request is held in the input register, then updates the clock state, which
// is also the result register; the result shows the time, adjust flag and latched
// digit drive after that event. With the output stalled the unit still takes one more
// request into its input register before it stalls.
// Register hold_limit (byte address 0, reset 15) sets the hold ticks after which the
// set button level decides adjust mode.
module multiplexed_clock_with_set_mode_unit import mcs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_command,
    input  logic               i_set_button_level,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [SEG_W-1:0]   o_segments,
    output logic [SEG_W-1:0]   o_digit_enables,
    output logic               o_adjust_active,
    output logic [HOUR_W-1:0]  o_hours_now,
    output logic [MIN_W-1:0]   o_minutes_now,
    output logic [SEC_W-1:0]   o_seconds_now,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic              r_in_valid;
    logic [2:0]        r_command;
    logic              r_level;
    logic              r_out_valid;
    logic [HOLD_W-1:0] r_hold_limit;
    t_state            r_state;
    t_state            n_state;
    logic              out_load;
    logic              in_take;
    logic              reg_sel;

    assign out_load   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !out_load;
    assign in_take    = i_in_valid && !o_in_stall;

    mcs_step u_step (
        .i_state            (r_state),
        .i_command          (r_command),
        .i_set_button_level (r_level),
        .i_hold_limit       (r_hold_limit),
        .o_state            (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (out_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command <= i_command;
            r_level   <= i_set_button_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{sec: '0, min: '0, hour: '0, scan: '0, hold: '0,
                             adjust: 1'b0, seg: SEG_RESET, en: EN_ALL_OFF};
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign reg_sel = (paddr[PADDR_W-1] == REG_HOLD_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_limit <= HOLD_LIMIT_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_hold_limit <= pwdata[HOLD_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_sel ? {{(PDATA_W-HOLD_W){1'b0}}, r_hold_limit} : '0;

    assign o_out_valid     = r_out_valid;
    assign o_segments      = r_state.seg;
    assign o_digit_enables = r_state.en;
    assign o_adjust_active = r_state.adjust;
    assign o_hours_now     = r_state.hour;
    assign o_minutes_now   = r_state.min;
    assign o_seconds_now   = r_state.sec;

endmodule

[rtl/mcs_step.sv]
// Next-state logic of the clock for one request.
module mcs_step import mcs_pkg::*; (
    input  t_state            i_state,
    input  logic [2:0]        i_command,
    input  logic              i_set_button_level,
    input  logic [HOLD_W-1:0] i_hold_limit,
    output t_state            o_state
);

    logic [SEC_W-1:0]  sec_inc;
    logic [MIN_W-1:0]  min_inc;
    logic [HOUR_W-1:0] hour_inc;
    logic              sec_wrap;
    logic              min_wrap;
    logic              hour_wrap;
    logic [HOLD_W-1:0] hold_inc;
    logic [SCAN_W-1:0] idx;
    logic [SCAN_W-1:0] idx_next;
    logic [5:0]        digit_src;
    logic [3:0]        digit_val;

    assign sec_inc   = i_state.sec + 1'b1;
    assign min_inc   = i_state.min + 1'b1;
    assign hour_inc  = i_state.hour + 1'b1;
    assign sec_wrap  = (sec_inc >= SEC_WRAP);
    assign min_wrap  = (min_inc >= MIN_WRAP);
    assign hour_wrap = (hour_inc >= HOUR_WRAP);
    assign hold_inc  = i_state.hold + 1'b1;

    assign idx      = (i_state.scan >= SCAN_W'(DIGIT_COUNT)) ? '0 : i_state.scan;
    assign idx_next = (idx == SCAN_W'(DIGIT_COUNT - 1)) ? '0 : idx + 1'b1;

    always_comb begin
        case (idx)
            3'd2, 3'd3: digit_src = i_state.min;
            3'd4, 3'd5: digit_src = {1'b0, i_state.hour};
            default:    digit_src = i_state.sec;
        endcase
        digit_val = idx[0] ? tens_of(digit_src) : units_of(digit_src);
    end

    always_comb begin
        o_state = i_state;
        case (t_cmd'(i_command))
            CMD_SECOND: begin
                o_state.sec = sec_wrap ? '0 : sec_inc;
                if (sec_wrap) begin
                    o_state.min = min_wrap ? '0 : min_inc;
                    if (min_wrap) begin
                        o_state.hour = hour_wrap ? '0 : hour_inc;
                    end
                end
            end
            CMD_SCAN: begin
                o_state.seg  = seg_font(digit_val);
                o_state.en   = digit_enable(idx);
                o_state.scan = idx_next;
            end
            CMD_HOLD: begin
                if (hold_inc == i_hold_limit) begin
                    o_state.adjust = i_set_button_level;
                    o_state.hold   = '0;
                end else begin
                    o_state.hold = hold_inc;
                end
            end
            CMD_SET: begin
                o_state.hold = '0;
            end
            CMD_HOUR: begin
                if (i_state.adjust) begin
                    o_state.hold = '0;
                    o_state.hour = hour_wrap ? '0 : hour_inc;
                end
            end
            CMD_MINUTE: begin
                if (i_state.adjust) begin
                    o_state.hold = '0;
                    o_state.min  = min_wrap ? '0 : min_inc;
                    if (min_wrap) begin
                        o_state.hour = hour_wrap ? '0 : hour_inc;
                    end
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule
